>>> rtl/assert_macros.svh
// Shared assertion macros. Every user has clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle property
`define SLFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition implies consequence in the following cycle
`define SLFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/slfp_pkg.sv
package slfp_pkg;

  localparam int COUNTER_WIDTH = 32;
  localparam int KIND_COUNT_W  = 32;
  localparam int NUM_KINDS     = 5;
  localparam int WIN_DEPTH     = 14;
  localparam int RESP_LEN      = 13;
  localparam int DATA_LEN      = 14;

  localparam logic [7:0] HDR0      = 8'hDE;
  localparam logic [7:0] HDR1      = 8'hAD;
  localparam logic [7:0] TRL0      = 8'hBE;
  localparam logic [7:0] TRL1      = 8'hEF;
  localparam logic [7:0] SUB_DELAY = 8'h02;
  localparam logic [7:0] SUB_OTHER = 8'h03;

  typedef enum logic {
    ITEM_BYTE  = 1'b0,
    ITEM_CLEAR = 1'b1
  } item_kind_e;

  typedef enum logic [2:0] {
    KIND_DELAY   = 3'd0,
    KIND_OTHER   = 3'd1,
    KIND_RAW     = 3'd2,
    KIND_DATA    = 3'd3,
    KIND_UNKNOWN = 3'd4
  } msg_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    msg_kind_e                 msg_kind;
    logic [31:0]               word_value;
    logic [15:0]               axis_x;
    logic [15:0]               axis_y;
    logic [15:0]               axis_z;
    logic [KIND_COUNT_W-1:0]   kind_count;
  } out_t;

  // Frame decision handed from the window to the counters and output stage
  typedef struct packed {
    logic        found;
    msg_kind_e   msg_kind;
    logic [31:0] word_value;
    logic [15:0] axis_x;
    logic [15:0] axis_y;
    logic [15:0] axis_z;
  } dec_t;

endpackage

>>> rtl/slfp_window.sv
`include "assert_macros.svh"

module slfp_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         rx_byte_i,
  output slfp_pkg::dec_t     dec_o
);
  import slfp_pkg::*;

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [3:0]                fill_q, fill_d;
  logic                      aligned;

  always_comb begin
    logic [WIN_DEPTH-1:0][7:0] w;
    logic [WIN_DEPTH-1:0][7:0] nw;
    logic [3:0]                f;
    logic                      resp;
    logic                      data;
    logic [WIN_DEPTH-1:0]      cand;
    logic                      hit;
    logic [3:0]                skip;
    logic [4:0]                idx;

    w = win_q;
    f = fill_q;
    if (fill_q < 4'(WIN_DEPTH)) begin
      w[fill_q] = rx_byte_i;
      f = fill_q + 4'd1;
    end
    // Window is always aligned to a header, so only the new byte can break it
    if (fill_q == 4'd0 && rx_byte_i != HDR0) begin
      f = 4'd0;
    end else if (fill_q == 4'd1 && rx_byte_i != HDR1) begin
      if (rx_byte_i == HDR0) begin
        f = 4'd1;
      end else begin
        f = 4'd0;
      end
    end

    resp = (f >= 4'(RESP_LEN)) && w[11] == TRL0 && w[12] == TRL1;
    data = !resp && (f >= 4'(DATA_LEN)) && w[12] == TRL0 && w[13] == TRL1;

    // Next header after an unknown-header drop; offsets 0 and 1 cannot start one
    cand = '0;
    for (int p = 2; p < WIN_DEPTH - 1; p++) begin
      cand[p] = (w[p] == HDR0) && (w[p+1] == HDR1);
    end
    cand[WIN_DEPTH-1] = (w[WIN_DEPTH-1] == HDR0);
    hit  = 1'b0;
    skip = 4'd0;
    for (int p = WIN_DEPTH - 1; p >= 2; p--) begin
      if (cand[p]) begin
        hit  = 1'b1;
        skip = 4'(p);
      end
    end
    for (int i = 0; i < WIN_DEPTH; i++) begin
      idx   = 5'(i) + {1'b0, skip};
      nw[i] = (idx < 5'(WIN_DEPTH)) ? w[idx[3:0]] : 8'h00;
    end

    win_d  = win_q;
    fill_d = fill_q;
    dec_o  = '0;
    if (step_i) begin
      win_d  = w;
      fill_d = f;
      if (resp) begin
        dec_o.found = 1'b1;
        if (w[6] == SUB_DELAY) begin
          dec_o.msg_kind   = KIND_DELAY;
          dec_o.word_value = {w[7], w[8], w[9], w[10]};
        end else if (w[6] == SUB_OTHER) begin
          dec_o.msg_kind = KIND_OTHER;
        end else begin
          dec_o.msg_kind = KIND_RAW;
        end
        // A full window keeps its last byte only if it can open a header
        if (f == 4'(WIN_DEPTH) && w[WIN_DEPTH-1] == HDR0) begin
          win_d[0] = HDR0;
          fill_d   = 4'd1;
        end else begin
          fill_d = 4'd0;
        end
      end else if (f >= 4'(DATA_LEN)) begin
        dec_o.found = 1'b1;
        if (data) begin
          dec_o.msg_kind   = KIND_DATA;
          dec_o.word_value = {w[2], w[3], w[4], w[5]};
          dec_o.axis_x     = {w[6], w[7]};
          dec_o.axis_y     = {w[8], w[9]};
          dec_o.axis_z     = {w[10], w[11]};
          fill_d           = 4'd0;
        end else begin
          dec_o.msg_kind = KIND_UNKNOWN;
          win_d          = nw;
          fill_d         = hit ? (4'(WIN_DEPTH) - skip) : 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 4'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign aligned = (fill_q == 4'd0 || win_q[0] == HDR0) && (fill_q < 4'd2 || win_q[1] == HDR1);

  `SLFP_ASSERT(a_fill_bound, fill_q < 4'(WIN_DEPTH), "window left full after a step")
  `SLFP_ASSERT(a_aligned, aligned, "window not aligned to header")

endmodule

>>> rtl/slfp_counters.sv
`include "assert_macros.svh"

module slfp_counters #(
  parameter int CounterWidth = slfp_pkg::COUNTER_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              clr_i,
  input  logic                              inc_i,
  input  slfp_pkg::msg_kind_e               kind_i,
  output logic [slfp_pkg::KIND_COUNT_W-1:0] count_o
);
  import slfp_pkg::*;

  logic [CounterWidth-1:0] cnt_q [NUM_KINDS];
  logic [CounterWidth-1:0] cnt_inc;
  logic                    all_zero;

  always_comb begin
    cnt_inc = '0;
    for (int i = 0; i < NUM_KINDS; i++) begin
      if (kind_i == 3'(i)) begin
        cnt_inc = cnt_q[i] + 1'b1;
      end
    end
    count_o = KIND_COUNT_W'(cnt_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KINDS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_KINDS; i++) begin
        if (clr_i) begin
          cnt_q[i] <= '0;
        end else if (inc_i && kind_i == 3'(i)) begin
          cnt_q[i] <= cnt_inc;
        end
      end
    end
  end

  assign all_zero = cnt_q[0] == '0 && cnt_q[1] == '0 && cnt_q[2] == '0 &&
                    cnt_q[3] == '0 && cnt_q[4] == '0;

  `SLFP_ASSERT_NEXT(a_clear_zero, clr_i, all_zero, "counters not cleared")

endmodule

>>> rtl/sensor_link_frame_parser_core.sv
// Sensor link frame parser.
// Input channel: one request per received link byte (kind ITEM_BYTE) or a
// counter clear (kind ITEM_CLEAR), handshake in_valid_i / in_stall_o.
// Output channel: one request per recognized frame or unknown-header drop,
// handshake out_valid_o / out_stall_i, carrying kind, value, axes and the
// incremented per-kind count. Clears and bytes that only extend the window
// produce nothing.
// A taken request waits in the input register, is decided from there and its
// result is written to the output register, where it stays until taken.
// Throughput: one request per cycle while the output is not stalled; the
// window decision (fixed compares, a 12-entry header search and a byte
// shifter) and the counter add are combinational between the input register and the output register.
// While the receiver stalls, the result stays in the output register and
// one more request is held in the input register; after that in_stall_o
// rises until the result is taken.
// Reset empties the byte window, zeroes all counters and clears the valid
// flags of both registers.
`include "assert_macros.svh"

module sensor_link_frame_parser_core #(
  parameter int CounterWidth = slfp_pkg::COUNTER_WIDTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  slfp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output slfp_pkg::out_t out_data_o
);
  import slfp_pkg::*;

  logic                    in_valid_q;
  in_t                     in_q;
  logic                    out_valid_q;
  out_t                    out_q;
  logic                    advance;
  logic                    step;
  logic                    clr;
  dec_t                    dec;
  logic [KIND_COUNT_W-1:0] count;
  logic                    out_blocked;
  logic                    axes_ok;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign step       = in_valid_q && advance && in_q.kind == ITEM_BYTE;
  assign clr        = in_valid_q && advance && in_q.kind == ITEM_CLEAR;

  slfp_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_q.rx_byte),
    .dec_o     (dec)
  );

  slfp_counters #(
    .CounterWidth (CounterWidth)
  ) u_counters (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (clr),
    .inc_i   (dec.found),
    .kind_i  (dec.msg_kind),
    .count_o (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= dec.found;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (advance && dec.found) begin
      out_q.msg_kind   <= dec.msg_kind;
      out_q.word_value <= dec.word_value;
      out_q.axis_x     <= dec.axis_x;
      out_q.axis_y     <= dec.axis_y;
      out_q.axis_z     <= dec.axis_z;
      out_q.kind_count <= count;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign out_blocked = out_valid_q && out_stall_i;
  assign axes_ok     = out_q.msg_kind == KIND_DATA ||
                       (out_q.axis_x == '0 && out_q.axis_y == '0 && out_q.axis_z == '0);

  `SLFP_ASSERT(a_stall_cause, !in_stall_o || out_blocked, "input stalled without a blocked result")
  `SLFP_ASSERT(a_axes_zero, !out_valid_q || axes_ok, "axes set on a non-data result")

endmodule
